[rtl/mfm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MDIO management frame master package
// Frame layout constants, operation codes and the result word shared by the
// sequencer and the top level.
// ----------------------------------------------------------------------------
package mfm_pkg;

    localparam int PREAMBLE_BITS = 32;
    localparam int FRAME_PERIODS = PREAMBLE_BITS + 34;
    localparam int READ_RELEASE_START = PREAMBLE_BITS + 14;
    localparam int READ_SAMPLE_START = PREAMBLE_BITS + 16;
    localparam int READ_SAMPLE_END = PREAMBLE_BITS + 32;
    localparam int WRITE_DRIVE_END = PREAMBLE_BITS + 32;

    localparam int HP_W = 10;
    localparam int IDX_W = 7;
    localparam int DATA_W = 16;
    localparam int ADDR_W = 5;

    localparam logic [HP_W-1:0] HALF_PERIOD_RESET = HP_W'(100);

    localparam logic [IDX_W-1:0] IDX_FRAME_END = IDX_W'(FRAME_PERIODS);
    localparam logic [IDX_W-1:0] IDX_RELEASE = IDX_W'(READ_RELEASE_START);
    localparam logic [IDX_W-1:0] IDX_SAMPLE_START = IDX_W'(READ_SAMPLE_START);
    localparam logic [IDX_W-1:0] IDX_SAMPLE_END = IDX_W'(READ_SAMPLE_END);
    localparam logic [IDX_W-1:0] IDX_WRITE_END = IDX_W'(WRITE_DRIVE_END);

    // Preamble ones sit just above the 32-bit header before alignment.
    localparam logic [63:0] PREAMBLE_MASK = ((64'd1 << PREAMBLE_BITS) - 64'd1) << 32;
    localparam int FRAME_ALIGN = 32 - PREAMBLE_BITS;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } mfm_op_t;

    // Frame opcode bits as sent on the wire.
    localparam logic [1:0] WIRE_OP_READ = 2'b10;
    localparam logic [1:0] WIRE_OP_WRITE = 2'b01;
    localparam logic [1:0] WIRE_START = 2'b01;
    localparam logic [1:0] WIRE_TURNAROUND = 2'b10;

    typedef struct packed {
        logic [DATA_W-1:0] write_data;
        logic [ADDR_W-1:0] register_address;
        logic [ADDR_W-1:0] phy_address;
        logic [1:0]        opcode;
        logic              mdio_in;
    } mfm_request_t;

    // Packed with mdc in bit 0, matching the output tdata layout.
    typedef struct packed {
        logic              read_done;
        logic [DATA_W-1:0] read_data;
        logic              accepted;
        logic              busy_res;
        logic              mdio_drive;
        logic              mdio_out;
        logic              mdc;
    } mfm_result_t;

    localparam int RESULT_W = $bits(mfm_result_t);

endpackage

[rtl/mdio_management_frame_master.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MDIO clause 22 management frame master
// Channel  | Direction | Contents
// s_axis   | in        | one system tick: request, addresses, data, MDIO level
// m_axis   | out       | pin levels and status after that tick
// cfg      | in        | MDC half period in ticks (10 bits, reset 100)
//
// Each input transfer yields one output transfer in the following cycle; a new
// transfer is taken every cycle while the output register is empty or drained.
// The sequencer state advances once per accepted transfer, not per clock.
// Reset is asynchronous and clears the frame state and the output valid.
// A stalled output holds its transfer and blocks input until it is taken.
// ----------------------------------------------------------------------------
module mdio_management_frame_master
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // [4:0] phy_address, [9:5] register_address, [25:10] write_data,
    // [26] mdio_in, [31:27] zero
    input  logic [31:0]              s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]               s_axis_tuser,

    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [0] mdc, [1] mdio_out, [2] mdio_drive, [3] busy_res, [4] accepted,
    // [20:5] read_data, [21] read_done, [23:22] zero
    output logic [23:0]              m_axis_tdata,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [mfm_pkg::HP_W-1:0] cfg_data
);

    logic [mfm_pkg::HP_W-1:0] half_period_reg;
    logic                     out_valid_reg;
    mfm_pkg::mfm_result_t     out_data_reg;
    mfm_pkg::mfm_request_t    req;
    mfm_pkg::mfm_result_t     result;
    logic                     step;

    assign cfg_ready = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign step = s_axis_tvalid && s_axis_tready;

    assign req.phy_address = s_axis_tdata[4:0];
    assign req.register_address = s_axis_tdata[9:5];
    assign req.write_data = s_axis_tdata[25:10];
    assign req.mdio_in = s_axis_tdata[26];
    assign req.opcode = s_axis_tuser;

    mfm_seq u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .half_period (half_period_reg),
        .req         (req),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_period_reg <= mfm_pkg::HALF_PERIOD_RESET;
        else if (cfg_valid && cfg_ready)
            half_period_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_data_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {2'b00, out_data_reg};

endmodule

[rtl/mfm_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MDIO frame sequencer
// Holds the MDC divider, frame shift register and read capture; advances by
// one system tick for every step and presents the resulting pin levels.
// ----------------------------------------------------------------------------
module mfm_seq
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [mfm_pkg::HP_W-1:0]   half_period,
    input  mfm_pkg::mfm_request_t      req,
    output mfm_pkg::mfm_result_t       result
);

    logic [63:0]                    shift_reg, shift_next;
    logic [mfm_pkg::DATA_W-1:0]     capture_reg, capture_next;
    logic [mfm_pkg::DATA_W-1:0]     hold_reg, hold_next;
    logic [mfm_pkg::IDX_W-1:0]      index_reg, index_next;
    logic [mfm_pkg::HP_W-1:0]       tick_reg, tick_next;
    logic                           level_reg, level_next;
    logic                           active_reg, active_next;
    logic                           is_read_reg, is_read_next;

    logic [mfm_pkg::HP_W-1:0]       hp_eff;
    logic [mfm_pkg::HP_W-1:0]       tick_inc;
    logic [mfm_pkg::IDX_W-1:0]      index_inc;
    logic                           start;
    logic                           start_read;
    logic [31:0]                    header;
    logic                           accepted;
    logic                           done;
    logic                           drive;

    assign hp_eff = (half_period == '0) ? mfm_pkg::HP_W'(1) : half_period;
    assign tick_inc = tick_reg + mfm_pkg::HP_W'(1);
    assign index_inc = index_reg + mfm_pkg::IDX_W'(1);
    assign start_read = (mfm_pkg::mfm_op_t'(req.opcode) == mfm_pkg::OP_READ);

    always_comb
    begin
        case (mfm_pkg::mfm_op_t'(req.opcode)) inside
            mfm_pkg::OP_READ, mfm_pkg::OP_WRITE: start = 1'b1;
            default:                             start = 1'b0;
        endcase
    end

    always_comb
    begin
        header = {mfm_pkg::WIRE_START,
                  start_read ? mfm_pkg::WIRE_OP_READ : mfm_pkg::WIRE_OP_WRITE,
                  req.phy_address, req.register_address,
                  start_read ? 18'd0 : {mfm_pkg::WIRE_TURNAROUND, req.write_data}};
    end

    always_comb
    begin
        shift_next = shift_reg;
        capture_next = capture_reg;
        hold_next = hold_reg;
        index_next = index_reg;
        tick_next = tick_reg;
        level_next = level_reg;
        active_next = active_reg;
        is_read_next = is_read_reg;
        accepted = 1'b0;
        done = 1'b0;

        if (active_reg)
        begin
            tick_next = tick_inc;
            if (tick_inc >= hp_eff)
            begin
                tick_next = '0;
                if (!level_reg)
                begin
                    // Rising MDC edge: the PHY's data bit is sampled here.
                    level_next = 1'b1;
                    if (is_read_reg && index_reg >= mfm_pkg::IDX_SAMPLE_START &&
                        index_reg < mfm_pkg::IDX_SAMPLE_END)
                    begin
                        capture_next = {capture_reg[mfm_pkg::DATA_W-2:0], req.mdio_in};
                    end
                end
                else
                begin
                    // Falling MDC edge closes the period and moves to the next bit.
                    level_next = 1'b0;
                    shift_next = {shift_reg[62:0], 1'b0};
                    index_next = index_inc;
                    if (index_inc >= mfm_pkg::IDX_FRAME_END)
                    begin
                        active_next = 1'b0;
                        index_next = '0;
                        if (is_read_reg)
                        begin
                            hold_next = capture_reg;
                            done = 1'b1;
                        end
                    end
                end
            end
        end
        else if (start)
        begin
            is_read_next = start_read;
            shift_next = (mfm_pkg::PREAMBLE_MASK | {32'd0, header}) << mfm_pkg::FRAME_ALIGN;
            capture_next = '0;
            index_next = '0;
            tick_next = '0;
            level_next = 1'b0;
            active_next = 1'b1;
            accepted = 1'b1;
        end
    end

    always_comb
    begin
        if (!active_next)
            drive = 1'b0;
        else if (is_read_next)
            drive = (index_next < mfm_pkg::IDX_RELEASE);
        else
            drive = (index_next < mfm_pkg::IDX_WRITE_END);

        result.mdc = active_next & level_next;
        result.mdio_out = drive & shift_next[63];
        result.mdio_drive = drive;
        result.busy_res = active_next;
        result.accepted = accepted;
        result.read_data = hold_next;
        result.read_done = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            capture_reg <= '0;
            hold_reg <= '0;
            index_reg <= '0;
            tick_reg <= '0;
            level_reg <= 1'b0;
            active_reg <= 1'b0;
            is_read_reg <= 1'b0;
        end
        else if (step)
        begin
            shift_reg <= shift_next;
            capture_reg <= capture_next;
            hold_reg <= hold_next;
            index_reg <= index_next;
            tick_reg <= tick_next;
            level_reg <= level_next;
            active_reg <= active_next;
            is_read_reg <= is_read_next;
        end
    end

endmodule

[rtl/mfm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MDIO frame master port checker
// Watches the output stream for pin and status combinations that the frame
// sequencer must never produce, and for stalled transfers that change.
// ----------------------------------------------------------------------------
module mfm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // A released line always reads back as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[2])
        else $error("mdio_out high while the line is released");

    // MDC and the data driver only toggle inside a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[0] || m_axis_tdata[2]) |-> m_axis_tdata[3])
        else $error("mdc or mdio_drive active outside a frame");

    // A started frame is busy; a finished read is not.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3] && !m_axis_tdata[21])
        else $error("accepted transfer not busy or coincident with read_done");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[21] |-> !m_axis_tdata[3] && !m_axis_tdata[2])
        else $error("read_done while a frame is still running");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output transfer changed");

endmodule

bind mdio_management_frame_master mfm_checker u_mfm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
